/* design/gbs_pkg.sv */
// Shared types, constants and the exponential factor table of the Gaussian ball sprite pixel core.
package gbs_pkg;

   localparam int MAX_SIZE          = 256;
   localparam int EXP_FRAC_BITS_DEF = 16;

   localparam int SIZE_W     = 9;
   localparam int RAD_W      = 12;
   localparam int SIG_W      = 20;
   localparam int COL_W      = 24;
   localparam int Q_W        = 19;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam int TAB_LO = 24;
   localparam int TAB_N  = 29;

   localparam logic [63:0] Q32_ONE = 64'h1_0000_0000;

   localparam logic [SIZE_W-1:0] IMAGE_SIZE_RST = 9'd32;
   localparam logic [RAD_W-1:0]  RADIUS_RST     = 12'd160;
   localparam logic [SIG_W-1:0]  SIGMA_RST      = 20'd1600;
   localparam logic [COL_W-1:0]  FG_COLOR_RST   = 24'h00FF7F;
   localparam logic [COL_W-1:0]  BKG_COLOR_RST  = 24'h000000;
   localparam logic              OUTLINE_RST    = 1'b0;

   localparam logic [7:0] GREY_LEVEL   = 8'd127;
   localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_SIZE    = 3'd0,
      CSR_RADIUS_Q4     = 3'd1,
      CSR_SIGMA_Q4      = 3'd2,
      CSR_FG_COLOR      = 3'd3,
      CSR_BKG_COLOR     = 3'd4,
      CSR_DEBUG_OUTLINE = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [7:0] row;
      logic [7:0] col;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rsp_type;

   typedef enum logic [1:0] {
      SEL_BKG,
      SEL_FG,
      SEL_GREY
   } sel_type;

   typedef struct packed {
      sel_type sel;
      logic    zero;
   } tag_type;

   typedef logic [31:0] exp_tab_type [TAB_N];

   // Entry i holds exp(-2^(i-TAB_LO)) in Q32, built from a truncated Taylor series and squaring.
   function automatic exp_tab_type build_exp_tab();
      exp_tab_type tab;
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] sq;
      int          sh;
      bit          done;
      for (int idx = 0; idx <= TAB_LO; idx++) begin
         sh   = TAB_LO - idx;
         sum  = Q32_ONE;
         term = Q32_ONE;
         done = 1'b0;
         for (int k = 1; k < 64; k++) begin
            if (!done) begin
               term = (term >> sh) / 64'(k);
               if (term == 64'd0) begin
                  done = 1'b1;
               end else if ((k % 2) == 1) begin
                  sum = sum - term;
               end else begin
                  sum = sum + term;
               end
            end
         end
         tab[idx] = sum[31:0];
      end
      for (int idx = TAB_LO + 1; idx < TAB_N; idx++) begin
         sq       = 64'(tab[idx-1]) * 64'(tab[idx-1]);
         tab[idx] = sq[63:32];
      end
      return tab;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_tab();

endpackage

/* design/gbs_div.sv */
// Pipelined restoring divider producing the fixed-point exponent, one quotient bit per stage.
module gbs_div
   import gbs_pkg::*;
#(
   parameter int FRAC_BITS = EXP_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [Q_W-1:0]         in_q,
   input  tag_type                in_tag,
   input  logic [SIG_W-1:0]       sigma,
   output logic                   out_valid,
   output logic [FRAC_BITS+4:0]   out_quot,
   output tag_type                out_tag
);

   localparam int QB  = FRAC_BITS + 5;
   localparam int N_W = Q_W + FRAC_BITS + 2;

   logic [N_W-1:0]   dividend;
   logic             valid_ff [QB];
   logic [SIG_W-1:0] rem_ff   [QB];
   logic [QB-1:0]    low_ff   [QB];
   logic [QB-1:0]    quot_ff  [QB];
   tag_type          tag_ff   [QB];

   assign dividend = {in_q, {(FRAC_BITS + 2){1'b0}}};

   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic             valid_prev;
      logic [SIG_W-1:0] rem_prev;
      logic [QB-1:0]    low_prev;
      logic [QB-1:0]    quot_prev;
      tag_type          tag_prev;
      logic [SIG_W:0]   trial;
      logic             ge;
      logic [SIG_W-1:0] rem_in;
      logic [QB-1:0]    quot_in;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = SIG_W'(dividend[N_W-1:QB]);
         assign low_prev   = dividend[QB-1:0];
         assign quot_prev  = '0;
         assign tag_prev   = in_tag;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign low_prev   = low_ff[k-1];
         assign quot_prev  = quot_ff[k-1];
         assign tag_prev   = tag_ff[k-1];
      end

      always_comb begin
         trial   = {rem_prev, low_prev[QB-1-k]};
         ge      = (trial >= {1'b0, sigma});
         rem_in  = ge ? SIG_W'(trial - {1'b0, sigma}) : trial[SIG_W-1:0];
         quot_in = {quot_prev[QB-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         low_ff[k]  <= low_prev;
         quot_ff[k] <= quot_in;
         tag_ff[k]  <= tag_prev;
      end
   end

   assign out_valid = valid_ff[QB-1];
   assign out_quot  = quot_ff[QB-1];
   assign out_tag   = tag_ff[QB-1];

endmodule

/* design/gbs_exp.sv */
// Pipelined exponential evaluator multiplying one table factor per exponent bit.
module gbs_exp
   import gbs_pkg::*;
#(
   parameter int FRAC_BITS = EXP_FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [FRAC_BITS+4:0] in_a,
   input  tag_type              in_tag,
   output logic                 out_valid,
   output logic [FRAC_BITS:0]   out_t,
   output tag_type              out_tag
);

   localparam int QB  = FRAC_BITS + 5;
   localparam int P_W = 33;

   logic           valid_ff [QB];
   logic [QB-1:0]  a_ff     [QB];
   logic [P_W-1:0] p_ff     [QB];
   tag_type        tag_ff   [QB];

   for (genvar k = 0; k < QB; k++) begin : g_stage
      localparam int IDX = k - FRAC_BITS + TAB_LO;

      logic           valid_prev;
      logic [QB-1:0]  a_prev;
      logic [P_W-1:0] p_prev;
      tag_type        tag_prev;
      logic [P_W+31:0] prod;
      logic [P_W-1:0] p_in;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign a_prev     = in_a;
         assign p_prev     = P_W'(Q32_ONE);
         assign tag_prev   = in_tag;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign a_prev     = a_ff[k-1];
         assign p_prev     = p_ff[k-1];
         assign tag_prev   = tag_ff[k-1];
      end

      always_comb begin
         prod = p_prev * EXP_TAB[IDX];
         p_in = a_prev[k] ? prod[P_W+31:32] : p_prev;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         a_ff[k]   <= a_prev;
         p_ff[k]   <= p_in;
         tag_ff[k] <= tag_prev;
      end
   end

   assign out_valid = valid_ff[QB-1];
   assign out_t     = p_ff[QB-1][32:32-FRAC_BITS];
   assign out_tag   = tag_ff[QB-1];

endmodule

/* design/gaussian_ball_sprite_pixel_core.sv */
// Top level of the Gaussian ball sprite pixel core: geometry stages, exponent pipelines, colour.
//
//   Channel   Ports                                   Handshake
//   request   start, busy, req_data                   taken when start is high and busy is low
//   result    rsp_valid, rsp_data                     one-cycle strobe, no back-pressure
//   config    csr_write, csr_index, csr_wdata         written on any edge with csr_write high, reset low
//
// One pixel is taken every clock while busy is low. The depth is set by the divider and the
// exponential chain, each resolving one exponent bit per stage, plus the geometry stages and
// the colour output register.
// Synchronous reset clears the valid bits and loads the register defaults; busy follows reset.
// There is no stall: every accepted transaction yields exactly one result transaction.
module gaussian_ball_sprite_pixel_core
   import gbs_pkg::*;
#(
   parameter int EXP_FRAC_BITS = EXP_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int QB       = EXP_FRAC_BITS + 5;
   localparam int TAIL_LAT = 2 * QB + 1;

   logic [SIZE_W-1:0] image_size_ff;
   logic [RAD_W-1:0]  radius_q4_ff;
   logic [SIG_W-1:0]  sigma_q4_ff;
   logic [COL_W-1:0]  fg_color_ff;
   logic [COL_W-1:0]  bkg_color_ff;
   logic              debug_outline_ff;

   logic [23:0]       rsq_ff;
   logic [24:0]       rhi_sq_ff;
   logic [23:0]       rlo_sq_ff;
   logic              rlo_neg_ff;
   logic [RAD_W:0]    rhi;
   logic [RAD_W-1:0]  rlo;

   logic              s0_valid_ff;
   req_type           s0_req_ff;

   logic [SIZE_W-1:0] size;
   logic [SIZE_W-1:0] size_m1;
   logic [7:0]        half;
   logic              s1_valid_ff;
   logic signed [9:0] s1_x2_ff;
   logic signed [9:0] s1_y2_ff;
   logic              s1_border_ff;
   logic signed [9:0] s1_x2_in;
   logic signed [9:0] s1_y2_in;
   logic              s1_border_in;

   logic signed [19:0] xsq;
   logic signed [19:0] ysq;
   logic               s2_valid_ff;
   logic [Q_W-1:0]     s2_q_ff;
   logic               s2_border_ff;
   logic [Q_W-1:0]     s2_q_in;

   logic [24:0]       q64;
   logic              in_ball;
   logic              ring;
   logic              s3_valid_ff;
   logic [Q_W-1:0]    s3_q_ff;
   tag_type           s3_tag_ff;
   tag_type           s3_tag_in;

   logic                 div_valid;
   logic [QB-1:0]        div_quot;
   tag_type              div_tag;
   logic                 exp_valid;
   logic [EXP_FRAC_BITS:0] exp_t;
   tag_type              exp_tag;

   logic [EXP_FRAC_BITS:0]   t_eff;
   logic [EXP_FRAC_BITS+8:0] prod_r;
   logic [EXP_FRAC_BITS+8:0] prod_g;
   logic [EXP_FRAC_BITS+8:0] prod_b;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff;
   rsp_type                  rsp_data_in;

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_size_ff    <= IMAGE_SIZE_RST;
         radius_q4_ff     <= RADIUS_RST;
         sigma_q4_ff      <= SIGMA_RST;
         fg_color_ff      <= FG_COLOR_RST;
         bkg_color_ff     <= BKG_COLOR_RST;
         debug_outline_ff <= OUTLINE_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_SIZE:    image_size_ff    <= csr_wdata[SIZE_W-1:0];
            CSR_RADIUS_Q4:     radius_q4_ff     <= csr_wdata[RAD_W-1:0];
            CSR_SIGMA_Q4:      sigma_q4_ff      <= csr_wdata[SIG_W-1:0];
            CSR_FG_COLOR:      fg_color_ff      <= csr_wdata[COL_W-1:0];
            CSR_BKG_COLOR:     bkg_color_ff     <= csr_wdata[COL_W-1:0];
            CSR_DEBUG_OUTLINE: debug_outline_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Squared radius bounds are registered, following the radius register in the next cycle.
   always_comb begin
      rhi = {1'b0, radius_q4_ff} + (RAD_W + 1)'(32);
      rlo = radius_q4_ff - RAD_W'(32);
   end

   always_ff @(posedge clock) begin
      rsq_ff     <= 24'(radius_q4_ff * radius_q4_ff);
      rhi_sq_ff  <= 25'(rhi * rhi);
      rlo_sq_ff  <= 24'(rlo * rlo);
      rlo_neg_ff <= (radius_q4_ff < RAD_W'(32));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= start && !busy;
         s1_valid_ff  <= s0_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= exp_valid;
      end
   end

   always_comb begin
      size    = (image_size_ff > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : image_size_ff;
      size_m1 = size - SIZE_W'(1);
      half    = size[SIZE_W-1:1];
      s1_x2_in = $signed({1'b0, s0_req_ff.row, 1'b1}) - $signed({1'b0, half, 1'b0});
      s1_y2_in = $signed({1'b0, s0_req_ff.col, 1'b1}) - $signed({1'b0, half, 1'b0});
      s1_border_in = (s0_req_ff.row == 8'd0) || (s0_req_ff.col == 8'd0) ||
                     ({1'b0, s0_req_ff.row} == size_m1) ||
                     ({1'b0, s0_req_ff.col} == size_m1);
   end

   always_comb begin
      xsq     = s1_x2_ff * s1_x2_ff;
      ysq     = s1_y2_ff * s1_y2_ff;
      s2_q_in = Q_W'(unsigned'(xsq)) + Q_W'(unsigned'(ysq));
   end

   always_comb begin
      q64     = {s2_q_ff, 6'd0};
      in_ball = (q64 < {1'b0, rsq_ff});
      ring    = (q64 < rhi_sq_ff) && (rlo_neg_ff || (q64 > {1'b0, rlo_sq_ff}));
      if (debug_outline_ff && (s2_border_ff || ring)) begin
         s3_tag_in.sel = SEL_GREY;
      end else if (in_ball) begin
         s3_tag_in.sel = SEL_FG;
      end else begin
         s3_tag_in.sel = SEL_BKG;
      end
      s3_tag_in.zero = (sigma_q4_ff == '0) || ({4'd0, s2_q_ff} >= {sigma_q4_ff, 3'd0});
   end

   always_ff @(posedge clock) begin
      s0_req_ff    <= req_data;
      s1_x2_ff     <= s1_x2_in;
      s1_y2_ff     <= s1_y2_in;
      s1_border_ff <= s1_border_in;
      s2_q_ff      <= s2_q_in;
      s2_border_ff <= s1_border_ff;
      s3_q_ff      <= s2_q_ff;
      s3_tag_ff    <= s3_tag_in;
      rsp_data_ff  <= rsp_data_in;
   end

   gbs_div #(
      .FRAC_BITS (EXP_FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_q      (s3_q_ff),
      .in_tag    (s3_tag_ff),
      .sigma     (sigma_q4_ff),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_tag   (div_tag)
   );

   gbs_exp #(
      .FRAC_BITS (EXP_FRAC_BITS)
   ) u_exp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_a      (div_quot),
      .in_tag    (div_tag),
      .out_valid (exp_valid),
      .out_t     (exp_t),
      .out_tag   (exp_tag)
   );

   always_comb begin
      t_eff  = exp_tag.zero ? '0 : exp_t;
      prod_r = fg_color_ff[23:16] * t_eff;
      prod_g = fg_color_ff[15:8] * t_eff;
      prod_b = fg_color_ff[7:0] * t_eff;
      rsp_data_in.alpha = ALPHA_OPAQUE;
      case (exp_tag.sel)
         SEL_GREY: begin
            rsp_data_in.red   = GREY_LEVEL;
            rsp_data_in.green = GREY_LEVEL;
            rsp_data_in.blue  = GREY_LEVEL;
         end
         SEL_FG: begin
            rsp_data_in.red   = prod_r[EXP_FRAC_BITS+7:EXP_FRAC_BITS];
            rsp_data_in.green = prod_g[EXP_FRAC_BITS+7:EXP_FRAC_BITS];
            rsp_data_in.blue  = prod_b[EXP_FRAC_BITS+7:EXP_FRAC_BITS];
         end
         default: begin
            rsp_data_in.red   = bkg_color_ff[23:16];
            rsp_data_in.green = bkg_color_ff[15:8];
            rsp_data_in.blue  = bkg_color_ff[7:0];
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // Reset empties the pipeline, so no stale transaction survives it.
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !s0_valid_ff && !rsp_valid)
      else $error("pipeline not flushed by reset");

   // Every result must come from a transaction that left the geometry stages in step.
   a_tail_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(s3_valid_ff, TAIL_LAT))
      else $error("result without matching transaction in the exponent pipelines");

   // A pixel inside the ball always lies within the outer ring bound.
   a_inside_in_ring: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && s3_tag_ff.sel == SEL_FG |-> ({s3_q_ff, 6'd0} < rhi_sq_ff))
      else $error("inside pixel beyond the outer ring bound");
`endif

endmodule
